// File: hw/rtl/svc_pkg.sv
package svc_pkg;

	localparam int WORD_W          = 64;
	localparam int BYTE_W          = 8;
	localparam int GROUP_W         = 7;
	localparam int FIRST_GROUP_W   = 6;
	localparam int SHIFT_W         = 7;
	localparam int SHIFT_STOP      = 64;
	localparam int VALUE_BITS_DEF  = 64;
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic {
		REQ_ENCODE = 1'b0,
		REQ_DECODE = 1'b1
	} req_kind_t;

	typedef enum logic {
		OUT_BYTE  = 1'b0,
		OUT_VALUE = 1'b1
	} out_kind_t;

	// classified word between front and back
	typedef struct packed {
		req_kind_t         kind;
		logic              neg;
		logic [WORD_W-1:0] data;
	} cmd_t;

endpackage

// File: hw/rtl/signed_varint_codec.sv
// signed varint codec, sign-magnitude, 64-bit values
// input channel: push/full, one word per accepted push; req_type selects an
//   encode of value or a decode of byte_in
// result channel: empty/pop, the oldest result sits on the ports while empty
//   is low and leaves on pop
// an encode word yields 1 to 10 result words, one byte each, last_byte on the
//   final one; a decode word yields a value result only on a byte with bit 7
//   clear, otherwise nothing
// accepted words go through a small queue to the back end; the first result
//   of a word goes from the queue into the result register if nothing is ahead
// throughput: one decode byte per cycle, one encoded byte per cycle, while the
//   receiver keeps popping; an encode word holds the back end until its last
//   byte (up to the tenth) is out, bound by the single result register
// reset clears the queue, the result register and the decoder state, so the
//   next decode byte is taken as a first byte
// a stalled receiver holds the result register; the back end then stops and
//   the queue fills until full rises
module signed_varint_codec #(
	parameter int VALUE_BITS  = svc_pkg::VALUE_BITS_DEF,
	parameter int QUEUE_DEPTH = svc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              req_type,
	input  logic signed [svc_pkg::WORD_W-1:0] value,
	input  logic [svc_pkg::BYTE_W-1:0]        byte_in,
	output logic                              empty,
	input  logic                              pop,
	output logic                              out_kind,
	output logic [svc_pkg::BYTE_W-1:0]        byte_out,
	output logic                              last_byte,
	output logic signed [svc_pkg::WORD_W-1:0] value_out,
	output logic                              overflow
);
	import svc_pkg::*;

	cmd_t front_cmd;
	cmd_t queue_cmd;
	logic queue_wr;
	logic queue_valid;
	logic queue_rd;

	// front: split incoming words into sign and magnitude or a decode byte
	svc_front u_front (
		.req_type (req_type),
		.value    (value),
		.byte_in  (byte_in),
		.cmd      (front_cmd)
	);

	assign queue_wr = push && !full;

	// decoupling queue, lets the input keep flowing while results wait
	svc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (queue_wr),
		.wr_data   (front_cmd),
		.full      (full),
		.rd_en     (queue_rd),
		.rd_data   (queue_cmd),
		.not_empty (queue_valid)
	);

	// back: byte sequencer for encode, accumulator for decode, result register
	svc_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (queue_valid),
		.cmd       (queue_cmd),
		.cmd_pop   (queue_rd),
		.empty     (empty),
		.pop       (pop),
		.out_kind  (out_kind),
		.byte_out  (byte_out),
		.last_byte (last_byte),
		.value_out (value_out),
		.overflow  (overflow)
	);

endmodule

// File: hw/rtl/svc_front.sv
module svc_front (
	input  logic                            req_type,
	input  logic signed [svc_pkg::WORD_W-1:0] value,
	input  logic [svc_pkg::BYTE_W-1:0]      byte_in,
	output svc_pkg::cmd_t                   cmd
);
	import svc_pkg::*;

	// encode words carry sign and magnitude, decode words carry the byte
	always_comb begin
		cmd = '0;
		if (req_type == REQ_DECODE) begin
			cmd.kind = REQ_DECODE;
			cmd.neg  = 1'b0;
			cmd.data = WORD_W'(byte_in);
		end else begin
			cmd.kind = REQ_ENCODE;
			cmd.neg  = value[WORD_W-1];
			cmd.data = value[WORD_W-1] ? (~value + 1'b1) : value;
		end
	end

endmodule

// File: hw/rtl/svc_queue.sv
module svc_queue #(
	parameter int DEPTH = svc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  svc_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output svc_pkg::cmd_t rd_data,
	output logic          not_empty
);
	import svc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hw/rtl/svc_back.sv
module svc_back #(
	parameter int VALUE_BITS = svc_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	input  svc_pkg::cmd_t                     cmd,
	output logic                              cmd_pop,
	output logic                              empty,
	input  logic                              pop,
	output logic                              out_kind,
	output logic [svc_pkg::BYTE_W-1:0]        byte_out,
	output logic                              last_byte,
	output logic signed [svc_pkg::WORD_W-1:0] value_out,
	output logic                              overflow
);
	import svc_pkg::*;

	localparam int EXT_W = VALUE_BITS + GROUP_W;

	// encoder sequencer
	logic              enc_busy_q;
	logic [WORD_W-1:0] rest_q;
	logic              enc_busy_d;
	logic [WORD_W-1:0] rest_d;

	// decoder accumulator
	logic [VALUE_BITS-1:0] acc_q;
	logic [SHIFT_W-1:0]    shift_q;
	logic                  neg_q;
	logic                  in_value_q;
	logic                  ovf_q;
	logic [VALUE_BITS-1:0] acc_d;
	logic [SHIFT_W-1:0]    shift_d;
	logic                  neg_d;
	logic                  in_value_d;
	logic                  ovf_d;

	// result register
	logic              out_valid_q;
	out_kind_t         out_kind_q;
	logic [BYTE_W-1:0] byte_out_q;
	logic              last_q;
	logic [WORD_W-1:0] value_out_q;
	logic              ovf_out_q;

	logic              slot_free;
	logic              res_valid;
	out_kind_t         res_kind;
	logic [BYTE_W-1:0] res_byte;
	logic              res_last;
	logic [WORD_W-1:0] res_value;
	logic              res_ovf;
	logic              more;
	logic [GROUP_W-1:0] chunk;
	logic [EXT_W-1:0]  ext;
	logic [WORD_W-1:0] mag_wide;

	assign slot_free = !out_valid_q || pop;
	assign cmd_pop   = cmd_valid && !enc_busy_q && slot_free;

	always_comb begin
		enc_busy_d = enc_busy_q;
		rest_d     = rest_q;
		acc_d      = acc_q;
		shift_d    = shift_q;
		neg_d      = neg_q;
		in_value_d = in_value_q;
		ovf_d      = ovf_q;
		res_valid  = 1'b0;
		res_kind   = OUT_BYTE;
		res_byte   = '0;
		res_last   = 1'b0;
		res_value  = '0;
		res_ovf    = 1'b0;
		more       = 1'b0;
		chunk      = cmd.data[GROUP_W-1:0];
		ext        = EXT_W'(chunk) << shift_q;
		mag_wide   = '0;
		if (enc_busy_q && slot_free) begin
			// later encoded bytes, seven magnitude bits each
			more       = |rest_q[WORD_W-1:GROUP_W];
			res_valid  = 1'b1;
			res_byte   = {more, rest_q[GROUP_W-1:0]};
			res_last   = !more;
			rest_d     = rest_q >> GROUP_W;
			enc_busy_d = more;
		end else if (cmd_pop) begin
			if (cmd.kind == REQ_ENCODE) begin
				more       = |cmd.data[WORD_W-1:FIRST_GROUP_W];
				res_valid  = 1'b1;
				res_byte   = {more, cmd.data[FIRST_GROUP_W-1:0], cmd.neg};
				res_last   = !more;
				rest_d     = cmd.data >> FIRST_GROUP_W;
				enc_busy_d = more;
			end else begin
				if (!in_value_q) begin
					neg_d   = cmd.data[0];
					acc_d   = VALUE_BITS'(cmd.data[FIRST_GROUP_W:1]);
					shift_d = SHIFT_W'(FIRST_GROUP_W);
					ovf_d   = 1'b0;
				end else begin
					if (shift_q >= SHIFT_W'(VALUE_BITS)) begin
						if (chunk != '0) begin
							ovf_d = 1'b1;
						end
					end else begin
						if (|ext[EXT_W-1:VALUE_BITS]) begin
							ovf_d = 1'b1;
						end
						acc_d = acc_q | ext[VALUE_BITS-1:0];
					end
					if (shift_q < SHIFT_W'(SHIFT_STOP)) begin
						shift_d = shift_q + SHIFT_W'(GROUP_W);
					end
				end
				more       = cmd.data[BYTE_W-1];
				in_value_d = more;
				if (!more) begin
					mag_wide  = WORD_W'(acc_d);
					res_valid = 1'b1;
					res_kind  = OUT_VALUE;
					res_value = neg_d ? (~mag_wide + 1'b1) : mag_wide;
					res_ovf   = ovf_d;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_busy_q  <= 1'b0;
			rest_q      <= '0;
			acc_q       <= '0;
			shift_q     <= '0;
			neg_q       <= 1'b0;
			in_value_q  <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			enc_busy_q <= enc_busy_d;
			rest_q     <= rest_d;
			acc_q      <= acc_d;
			shift_q    <= shift_d;
			neg_q      <= neg_d;
			in_value_q <= in_value_d;
			ovf_q      <= ovf_d;
			if (res_valid) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_kind_q  <= res_kind;
			byte_out_q  <= res_byte;
			last_q      <= res_last;
			value_out_q <= res_value;
			ovf_out_q   <= res_ovf;
		end
	end

	assign empty     = !out_valid_q;
	assign out_kind  = out_kind_q;
	assign byte_out  = byte_out_q;
	assign last_byte = last_q;
	assign value_out = value_out_q;
	assign overflow  = ovf_out_q;

	a_no_pop_while_encoding: assert property (@(posedge clk) disable iff (!arst_n)
		enc_busy_q |-> !cmd_pop)
		else $error("queue read while encode sequence active");

	a_result_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> slot_free)
		else $error("result produced into occupied output register");

	a_shift_bound: assert property (@(posedge clk) disable iff (!arst_n)
		shift_q <= SHIFT_W'(SHIFT_STOP + GROUP_W - 1))
		else $error("decoder shift position beyond stop point");

	a_busy_has_rest: assert property (@(posedge clk) disable iff (!arst_n)
		enc_busy_q |-> (rest_q != '0))
		else $error("encode sequence active with nothing left");

endmodule

// File: bench/svc_checker.sv
`timescale 1ns / 100ps

// watches both channels of the codec, predicts every result word and
// compares each popped word with the oldest one still awaited
module svc_checker #(
	parameter int VALUE_BITS = svc_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic                              full,
	input  logic                              req_type,
	input  logic [svc_pkg::WORD_W-1:0]        value,
	input  logic [svc_pkg::BYTE_W-1:0]        byte_in,
	input  logic                              empty,
	input  logic                              pop,
	input  logic                              out_kind,
	input  logic [svc_pkg::BYTE_W-1:0]        byte_out,
	input  logic                              last_byte,
	input  logic [svc_pkg::WORD_W-1:0]        value_out,
	input  logic                              overflow,
	output int                                bad_words,
	output int                                words_outstanding
);

	import svc_pkg::*;

	localparam logic [WORD_W-1:0] MAG_MASK =
		(VALUE_BITS >= WORD_W) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);

	typedef struct {
		out_kind_t         kind;
		logic [BYTE_W-1:0] enc_byte;
		logic              last;
		logic [WORD_W-1:0] dec_value;
		logic              ovf;
	} codec_word_t;

	codec_word_t       result_words_q[$];
	codec_word_t       awaited;

	// decoder state
	logic [WORD_W-1:0] acc_mag;
	int                acc_shift;
	logic              acc_neg;
	logic              acc_open;
	logic              acc_ovf;

	task automatic flag_bad(input string msg);
		bad_words++;
		if (bad_words <= 10) begin
			$display("%t svc_checker: %s", $time, msg);
		end
	endtask

	// append a predicted word behind the ones already awaited
	task automatic book_word(input codec_word_t w);
		result_words_q = {result_words_q, w};
	endtask

	task automatic encode_value(input logic [WORD_W-1:0] v);
		logic              neg;
		logic [WORD_W-1:0] mag;
		logic [WORD_W-1:0] rest;
		logic [BYTE_W-1:0] cur;
		codec_word_t       w;
		int                n;
		logic              done;
		neg  = v[WORD_W-1];
		mag  = neg ? (64'd0 - v) : v;
		cur  = {1'b0, mag[5:0], neg};
		rest = mag >> FIRST_GROUP_W;
		n    = 0;
		done = 1'b0;
		while (!done) begin
			w.kind      = OUT_BYTE;
			w.dec_value = '0;
			w.ovf       = 1'b0;
			w.last      = (rest == 0);
			w.enc_byte  = cur | (w.last ? 8'h00 : 8'h80);
			book_word(w);
			n++;
			if (w.last || n >= 10) begin
				done = 1'b1;
			end else begin
				cur  = {1'b0, rest[6:0]};
				rest = rest >> GROUP_W;
			end
		end
	endtask

	task automatic decode_byte(input logic [BYTE_W-1:0] b);
		logic [WORD_W-1:0] chunk;
		int                room;
		codec_word_t       w;
		if (!acc_open) begin
			acc_neg   = b[0];
			acc_mag   = {58'd0, b[6:1]} & MAG_MASK;
			acc_shift = FIRST_GROUP_W;
			acc_ovf   = 1'b0;
		end else begin
			chunk = {57'd0, b[6:0]};
			if (acc_shift >= VALUE_BITS) begin
				if (chunk != 0) begin
					acc_ovf = 1'b1;
				end
			end else begin
				room = VALUE_BITS - acc_shift;
				if (room < GROUP_W && (chunk >> room) != 0) begin
					acc_ovf = 1'b1;
				end
				acc_mag = (acc_mag | (chunk << acc_shift)) & MAG_MASK;
			end
			if (acc_shift < SHIFT_STOP) begin
				acc_shift += GROUP_W;
			end
		end
		acc_open = b[7];
		if (!b[7]) begin
			w.kind      = OUT_VALUE;
			w.enc_byte  = '0;
			w.last      = 1'b0;
			w.dec_value = acc_neg ? (64'd0 - acc_mag) : acc_mag;
			w.ovf       = acc_ovf;
			book_word(w);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_words_q.delete();
			acc_mag           = '0;
			acc_shift         = 0;
			acc_neg           = 1'b0;
			acc_open          = 1'b0;
			acc_ovf           = 1'b0;
			words_outstanding = 0;
		end else begin
			if (pop && !empty) begin
				if (result_words_q.size() == 0) begin
					flag_bad($sformatf("unexpected word kind %0d byte %02h last %0b val %016h ovf %0b",
						out_kind, byte_out, last_byte, value_out, overflow));
				end else begin
					awaited = result_words_q.pop_front();
					if (out_kind !== awaited.kind || byte_out !== awaited.enc_byte ||
						last_byte !== awaited.last || value_out !== awaited.dec_value ||
						overflow !== awaited.ovf) begin
						flag_bad($sformatf({"mismatch exp kind %0d byte %02h last %0b ",
							"val %016h ovf %0b, got kind %0d byte %02h last %0b ",
							"val %016h ovf %0b"},
							awaited.kind, awaited.enc_byte, awaited.last,
							awaited.dec_value, awaited.ovf, out_kind, byte_out,
							last_byte, value_out, overflow));
					end
				end
			end
			if (push && !full) begin
				if (req_type == REQ_ENCODE) begin
					encode_value(value);
				end else begin
					decode_byte(byte_in);
				end
			end
			words_outstanding = result_words_q.size();
		end
	end

endmodule

// File: bench/tb_signed_varint_codec.sv
`timescale 1ns / 100ps

// stimulus and verdict for the signed varint codec; all prediction and
// comparison sits in svc_checker beside the block
module tb_signed_varint_codec;

	import svc_pkg::*;

	localparam int ITEM_TARGET  = 330;
	localparam int HOLD_CYCLES  = 120;     // long receiver hold-off, fills the queue
	localparam int DRAIN_CYCLES = 16;      // settle time once nothing is awaited
	localparam int CYCLE_LIMIT  = 800000;

	logic                      clk;
	logic                      arst_n;
	logic                      push;
	logic                      full;
	logic                      req_type;
	logic signed [WORD_W-1:0]  value;
	logic [BYTE_W-1:0]         byte_in;
	logic                      empty;
	logic                      pop;
	logic                      out_kind;
	logic [BYTE_W-1:0]         byte_out;
	logic                      last_byte;
	logic signed [WORD_W-1:0]  value_out;
	logic                      overflow;

	int                        bad_words;
	int                        words_outstanding;
	int                        words_sent;
	int                        cycle_count;
	int                        sender_burst;   // words still to send back to back
	bit                        squeeze;        // asks the receiver for a long hold-off

	signed_varint_codec u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req_type  (req_type),
		.value     (value),
		.byte_in   (byte_in),
		.empty     (empty),
		.pop       (pop),
		.out_kind  (out_kind),
		.byte_out  (byte_out),
		.last_byte (last_byte),
		.value_out (value_out),
		.overflow  (overflow)
	);

	svc_checker u_chk (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.req_type          (req_type),
		.value             (value),
		.byte_in           (byte_in),
		.empty             (empty),
		.pop               (pop),
		.out_kind          (out_kind),
		.byte_out          (byte_out),
		.last_byte         (last_byte),
		.value_out         (value_out),
		.overflow          (overflow),
		.bad_words         (bad_words),
		.words_outstanding (words_outstanding)
	);

	always #1 clk = ~clk;

	// watchdog: a hung handshake or a word that never shows ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// sender idling: mostly no gap or a short one, now and then a long one,
	// and every so often a run of words with no gap at all
	function automatic int pick_gap();
		int r;
		if (sender_burst > 0) begin
			sender_burst--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			sender_burst = $urandom_range(10, 40);
			return 0;
		end
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// random value, spread over all magnitudes, either sign, with the
	// extremes turning up now and then
	function automatic logic [WORD_W-1:0] pick_value();
		logic [WORD_W-1:0] v;
		int                r;
		r = $urandom_range(0, 19);
		v = {$urandom(), $urandom()} >> $urandom_range(0, 63);
		case (r)
			0: v = 64'h8000_0000_0000_0000;
			1: v = 64'h7FFF_FFFF_FFFF_FFFF;
			2: v = 64'd0;
			default: if ($urandom_range(0, 1) == 1) v = 64'd0 - v;
		endcase
		return v;
	endfunction

	// offers one word and returns at the edge that takes it; push stays high
	// when the next word follows straight away, the unused field gets junk
	task automatic send_word(input req_kind_t kind, input logic [WORD_W-1:0] v,
		input logic [BYTE_W-1:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push     <= 1'b1;
		req_type <= kind;
		value    <= (kind == REQ_ENCODE) ? v : {$urandom(), $urandom()};
		byte_in  <= (kind == REQ_DECODE) ? b : 8'($urandom());
		do @(posedge clk); while (full);
		words_sent++;
	endtask

	// well-formed decode stream: continue bit on all but the final byte,
	// random groups, the odd encode slipped in between bytes
	task automatic send_stream(input int len);
		logic [BYTE_W-1:0] b;
		int                k;
		for (k = 0; k < len; k++) begin
			b    = 8'($urandom());
			b[7] = (k != len - 1);
			send_word(REQ_DECODE, 64'd0, b);
			if (k != len - 1 && $urandom_range(0, 7) == 0) begin
				send_word(REQ_ENCODE, pick_value(), 8'h00);
			end
		end
	endtask

	// receiver: pop runs and stalls of random length, plus one long
	// hold-off when the sender asks for it
	initial begin
		int r;
		int len;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (squeeze) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				squeeze = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					pop <= 1'b1;
					len = $urandom_range(1, 12);
				end else if (r < 55) begin
					pop <= 1'b1;
					len = $urandom_range(30, 60);
				end else if (r < 90) begin
					pop <= 1'b0;
					len = $urandom_range(1, 3);
				end else begin
					pop <= 1'b0;
					len = $urandom_range(8, 30);
				end
				repeat (len - 1) @(posedge clk);
			end
		end
	end

	initial begin
		int r;
		int len;
		int k;
		clk          = 1'b0;
		arst_n       = 1'b0;
		push         = 1'b0;
		req_type     = REQ_ENCODE;
		value        = '0;
		byte_in      = '0;
		cycle_count  = 0;
		words_sent   = 0;
		sender_burst = 0;
		squeeze      = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// encode extremes: zero, smallest magnitudes, the one-byte limit and
		// the first two-byte values, then the widest values
		send_word(REQ_ENCODE, 64'd0, 8'h00);
		send_word(REQ_ENCODE, 64'd1, 8'h00);
		send_word(REQ_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
		send_word(REQ_ENCODE, 64'd63, 8'h00);
		send_word(REQ_ENCODE, 64'd64, 8'h00);
		send_word(REQ_ENCODE, 64'hFFFF_FFFF_FFFF_FFC0, 8'h00);
		send_word(REQ_ENCODE, 64'h7FFF_FFFF_FFFF_FFFF, 8'h00);
		// most negative value, magnitude 2^63 over ten bytes
		send_word(REQ_ENCODE, 64'h8000_0000_0000_0000, 8'h00);

		// negative zero and plain zero as single-byte decodes
		send_word(REQ_DECODE, 64'd0, 8'h01);
		send_word(REQ_DECODE, 64'd0, 8'h00);

		// over-long decode stream: the group at bit 62 loses bits, the shift
		// stops growing, a later nonzero group is dropped too; an encode in
		// the middle must leave the decoder alone
		send_word(REQ_DECODE, 64'd0, 8'h81);
		for (k = 0; k < 4; k++) send_word(REQ_DECODE, 64'd0, 8'hFF);
		send_word(REQ_ENCODE, 64'h8000_0000_0000_0001, 8'h00);
		for (k = 0; k < 5; k++) send_word(REQ_DECODE, 64'd0, 8'hFF);
		send_word(REQ_DECODE, 64'd0, 8'h7F);

		// random part opens with the long hold-off while words keep coming
		squeeze = 1'b1;
		while (words_sent < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				k   = $urandom_range(0, 9);
				len = (k < 6) ? $urandom_range(1, 4) :
					(k < 9) ? $urandom_range(5, 10) : $urandom_range(11, 14);
				send_stream(len);
			end else if (r < 80) begin
				send_word(REQ_ENCODE, pick_value(), 8'h00);
			end else begin
				// stray byte: may open, extend or close a stream
				send_word(REQ_DECODE, 64'd0, 8'($urandom()));
			end
		end
		push <= 1'b0;

		// let the last word be booked before looking at the count
		@(posedge clk);
		wait (words_outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (bad_words == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
